// File: design/tcr_pkg.sv
`default_nettype none

package tcr_pkg;

  // Screen geometry
  localparam int SCREEN_COLS = 80;
  localparam int SCREEN_ROWS = 25;
  localparam int CELL_COUNT  = SCREEN_COLS * SCREEN_ROWS;
  localparam int ADDR_W      = $clog2(CELL_COUNT);
  localparam int CNT_W       = $clog2(CELL_COUNT + 1);

  // Field widths of the command and result items
  localparam int OP_W  = 4;
  localparam int CH_W  = 8;
  localparam int COL_W = 7;
  localparam int ROW_W = 5;
  localparam int VM_W  = 2;

  // Attributes and special characters
  localparam logic [7:0] ATTR_NORMAL  = 8'h07;
  localparam logic [7:0] ATTR_BRIGHT  = 8'h0f;
  localparam logic [7:0] ATTR_REVERSE = 8'h70;
  localparam logic [7:0] ATTR_BLINK   = 8'h87;
  localparam logic [7:0] CH_BLANK     = 8'h20;
  localparam logic [7:0] CH_TILDE     = 8'h7e;
  localparam logic [7:0] CH_NEWLINE   = 8'h0a;
  localparam logic [7:0] CH_BACKSPACE = 8'h08;

  typedef enum logic [OP_W-1:0] {
    OP_PUT       = 4'd0,
    OP_SHOW      = 4'd1,
    OP_HIDE      = 4'd2,
    OP_SET_POS   = 4'd3,
    OP_SET_MODE  = 4'd4,
    OP_CLEAR     = 4'd5,
    OP_CLEAR_EOL = 4'd6,
    OP_GET_POS   = 4'd7,
    OP_GET_CHAR  = 4'd8,
    OP_READ_CELL = 4'd9
  } opcode_t;

  typedef enum logic [2:0] {
    S_CLR,
    S_IDLE,
    S_EXEC,
    S_SCR,
    S_EOL,
    S_REP,
    S_DONE
  } state_t;

  typedef struct packed {
    logic [7:0] ch;
    logic [7:0] attr;
  } cell_t;

  typedef struct packed {
    logic              we;
    logic [ADDR_W-1:0] waddr;
    cell_t             wdata;
    logic              re;
    logic [ADDR_W-1:0] raddr;
  } mem_req_t;

  typedef struct packed {
    logic [OP_W-1:0]  opcode;
    logic [CH_W-1:0]  char_code;
    logic [COL_W-1:0] column;
    logic [ROW_W-1:0] row;
    logic [VM_W-1:0]  video_mode;
  } cmd_t;

  typedef struct packed {
    logic             status;
    logic [ROW_W-1:0] cursor_row;
    logic [COL_W-1:0] cursor_col;
    logic [7:0]       char_out;
    logic [7:0]       attr_out;
  } rsp_t;

  function automatic logic [7:0] mode_attr(input logic [VM_W-1:0] vm);
    logic [7:0] a;
    case (vm)
      2'd0:    a = ATTR_NORMAL;
      2'd1:    a = ATTR_BRIGHT;
      2'd2:    a = ATTR_REVERSE;
      default: a = ATTR_BLINK;
    endcase
    return a;
  endfunction

  function automatic logic [ADDR_W-1:0] cell_addr(input logic [ROW_W-1:0] r,
                                                  input logic [COL_W-1:0] c);
    return ADDR_W'(int'(r) * SCREEN_COLS + int'(c));
  endfunction

endpackage

`default_nettype wire

// File: design/tcr_if.sv
`default_nettype none

// Command channel
interface tcr_in_if;
  import tcr_pkg::*;
  logic             valid;
  logic             ready;
  logic [OP_W-1:0]  opcode;
  logic [CH_W-1:0]  char_code;
  logic [COL_W-1:0] column;
  logic [ROW_W-1:0] row;
  logic [VM_W-1:0]  video_mode;

  modport source (output valid, opcode, char_code, column, row, video_mode, input ready);
  modport sink   (input valid, opcode, char_code, column, row, video_mode, output ready);
endinterface

// Result channel
interface tcr_out_if;
  import tcr_pkg::*;
  logic             valid;
  logic             ready;
  logic             status;
  logic [ROW_W-1:0] cursor_row;
  logic [COL_W-1:0] cursor_col;
  logic [7:0]       char_out;
  logic [7:0]       attr_out;

  modport source (output valid, status, cursor_row, cursor_col, char_out, attr_out,
                  input ready);
  modport sink   (input valid, status, cursor_row, cursor_col, char_out, attr_out,
                  output ready);
endinterface

`default_nettype wire

// File: design/tcr_cell_ram.sv
`default_nettype none

module tcr_cell_ram (
  input  wire              clk,
  input  tcr_pkg::mem_req_t mreq,
  output tcr_pkg::cell_t    rdata
);
  import tcr_pkg::*;

  cell_t mem [CELL_COUNT];

  // Write port
  always_ff @(posedge clk) begin
    if (mreq.we) begin
      mem[mreq.waddr] <= mreq.wdata;
    end
  end

  // Registered read port, hold data while not enabled
  always_ff @(posedge clk) begin
    if (mreq.re) begin
      rdata <= mem[mreq.raddr];
    end
  end

endmodule

`default_nettype wire

// File: design/tcr_ctrl.sv
`default_nettype none

module tcr_ctrl (
  input  wire               clk,
  input  wire               rst_n,
  input  wire               in_valid,
  output logic              in_ready,
  input  tcr_pkg::cmd_t     in_cmd,
  output logic              rsp_valid,
  input  wire               rsp_ready,
  output tcr_pkg::rsp_t     rsp,
  output tcr_pkg::mem_req_t mreq,
  input  tcr_pkg::cell_t    rdata
);
  import tcr_pkg::*;

  state_t           state_r, state_nxt;
  cmd_t             cmd_r, cmd_nxt;
  logic [ROW_W-1:0] cur_row_r, cur_row_nxt;
  logic [COL_W-1:0] cur_col_r, cur_col_nxt;
  logic             hidden_r, hidden_nxt;
  logic [VM_W-1:0]  mode_r, mode_nxt;
  logic [CNT_W-1:0] cnt_r, cnt_nxt;
  logic [COL_W-1:0] eol_col_r, eol_col_nxt;
  logic             clr_report_r, clr_report_nxt;
  logic             status_r, status_nxt;
  logic             zero_r, zero_nxt;
  logic             rep_we_r, rep_we_nxt;
  logic [7:0]       rep_attr_r, rep_attr_nxt;
  logic             rep_cell_r, rep_cell_nxt;
  logic             fwd_hit_r, fwd_hit_nxt;
  cell_t            fwd_data_r, fwd_data_nxt;

  logic [ADDR_W-1:0] cur_addr;
  logic [ADDR_W-1:0] rep_addr;
  logic [CNT_W-1:0]  rd_src;
  logic [CNT_W-1:0]  wr_ptr;
  logic              shown;
  logic              printable;
  logic              in_range;
  logic              last_col;
  logic              last_row;
  logic              accept;
  cell_t             blank_cell;
  cell_t             rep_src;

  assign cur_addr   = cell_addr(cur_row_r, cur_col_r);
  assign rep_addr   = rep_cell_r ? cell_addr(cmd_r.row, cmd_r.column) : cur_addr;
  assign rd_src     = cnt_r + CNT_W'(SCREEN_COLS);
  assign wr_ptr     = cnt_r - CNT_W'(1);
  assign shown      = !hidden_r;
  assign printable  = (cmd_r.char_code >= CH_BLANK) && (cmd_r.char_code <= CH_TILDE);
  assign in_range   = (int'(cmd_r.column) < SCREEN_COLS) && (int'(cmd_r.row) < SCREEN_ROWS);
  assign last_col   = (cur_col_r == COL_W'(SCREEN_COLS - 1));
  assign last_row   = (cur_row_r == ROW_W'(SCREEN_ROWS - 1));
  assign blank_cell = '{ch: CH_BLANK, attr: ATTR_NORMAL};

  // Take a command when idle or while handing off the last result
  assign in_ready = (state_r == S_IDLE) || ((state_r == S_DONE) && rsp_ready);
  assign accept   = in_valid && in_ready;

  // Result of the finished command
  assign rsp_valid      = (state_r == S_DONE);
  assign rep_src        = fwd_hit_r ? fwd_data_r : rdata;
  assign rsp.status     = status_r;
  assign rsp.cursor_row = cur_row_r;
  assign rsp.cursor_col = cur_col_r;
  assign rsp.char_out   = zero_r ? 8'h00 : rep_src.ch;
  assign rsp.attr_out   = zero_r ? 8'h00 : rep_src.attr;

  // State registers
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r      <= S_CLR;
      cur_row_r    <= '0;
      cur_col_r    <= '0;
      hidden_r     <= 1'b0;
      mode_r       <= '0;
      cnt_r        <= '0;
      clr_report_r <= 1'b0;
    end else begin
      state_r      <= state_nxt;
      cur_row_r    <= cur_row_nxt;
      cur_col_r    <= cur_col_nxt;
      hidden_r     <= hidden_nxt;
      mode_r       <= mode_nxt;
      cnt_r        <= cnt_nxt;
      clr_report_r <= clr_report_nxt;
    end
  end

  // Command and report registers
  always_ff @(posedge clk) begin
    cmd_r      <= cmd_nxt;
    eol_col_r  <= eol_col_nxt;
    status_r   <= status_nxt;
    zero_r     <= zero_nxt;
    rep_we_r   <= rep_we_nxt;
    rep_attr_r <= rep_attr_nxt;
    rep_cell_r <= rep_cell_nxt;
    fwd_hit_r  <= fwd_hit_nxt;
    fwd_data_r <= fwd_data_nxt;
  end

  // Sequencer
  always_comb begin
    state_nxt      = state_r;
    cmd_nxt        = cmd_r;
    cur_row_nxt    = cur_row_r;
    cur_col_nxt    = cur_col_r;
    hidden_nxt     = hidden_r;
    mode_nxt       = mode_r;
    cnt_nxt        = cnt_r;
    eol_col_nxt    = eol_col_r;
    clr_report_nxt = clr_report_r;
    status_nxt     = status_r;
    zero_nxt       = zero_r;
    rep_we_nxt     = rep_we_r;
    rep_attr_nxt   = rep_attr_r;
    rep_cell_nxt   = rep_cell_r;
    fwd_hit_nxt    = fwd_hit_r;
    fwd_data_nxt   = fwd_data_r;
    mreq           = '0;

    case (state_r)
      // Blank every cell, one per cycle
      S_CLR: begin
        mreq.we    = 1'b1;
        mreq.waddr = cnt_r[ADDR_W-1:0];
        mreq.wdata = blank_cell;
        if (cnt_r == CNT_W'(CELL_COUNT - 1)) begin
          cnt_nxt = '0;
          if (clr_report_r) begin
            clr_report_nxt = 1'b0;
            cur_row_nxt    = '0;
            cur_col_nxt    = '0;
            rep_we_nxt     = 1'b1;
            rep_attr_nxt   = ATTR_REVERSE;
            state_nxt      = S_REP;
          end else begin
            state_nxt = S_IDLE;
          end
        end else begin
          cnt_nxt = cnt_r + CNT_W'(1);
        end
      end

      S_IDLE: begin
        if (accept) begin
          cmd_nxt   = in_cmd;
          state_nxt = S_EXEC;
        end
      end

      // Apply the command to the cursor and its old cell
      S_EXEC: begin
        status_nxt   = 1'b0;
        zero_nxt     = 1'b0;
        rep_we_nxt   = 1'b0;
        rep_attr_nxt = ATTR_REVERSE;
        rep_cell_nxt = 1'b0;
        state_nxt    = S_REP;
        case (cmd_r.opcode)
          OP_PUT: begin
            if (printable) begin
              mreq.we    = 1'b1;
              mreq.waddr = cur_addr;
              mreq.wdata = '{ch: cmd_r.char_code, attr: mode_attr(mode_r)};
              rep_we_nxt = shown;
              if (last_col) begin
                cur_col_nxt = '0;
                if (last_row) begin
                  cnt_nxt   = '0;
                  state_nxt = S_SCR;
                end else begin
                  cur_row_nxt = cur_row_r + ROW_W'(1);
                end
              end else begin
                cur_col_nxt = cur_col_r + COL_W'(1);
              end
            end else if (cmd_r.char_code == CH_NEWLINE) begin
              mreq.we     = shown;
              mreq.waddr  = cur_addr;
              mreq.wdata  = blank_cell;
              rep_we_nxt  = shown;
              cur_col_nxt = '0;
              if (last_row) begin
                cnt_nxt   = '0;
                state_nxt = S_SCR;
              end else begin
                cur_row_nxt = cur_row_r + ROW_W'(1);
              end
            end else if ((cmd_r.char_code == CH_BACKSPACE) &&
                         ((cur_row_r != '0) || (cur_col_r != '0))) begin
              mreq.we    = shown;
              mreq.waddr = cur_addr;
              mreq.wdata = blank_cell;
              rep_we_nxt = shown;
              if (cur_col_r == '0) begin
                cur_col_nxt = COL_W'(SCREEN_COLS - 1);
                cur_row_nxt = cur_row_r - ROW_W'(1);
              end else begin
                cur_col_nxt = cur_col_r - COL_W'(1);
              end
            end
          end
          OP_SHOW: begin
            hidden_nxt = 1'b0;
            rep_we_nxt = 1'b1;
          end
          OP_HIDE: begin
            hidden_nxt   = 1'b1;
            rep_we_nxt   = 1'b1;
            rep_attr_nxt = ATTR_NORMAL;
          end
          OP_SET_POS: begin
            if (in_range) begin
              cur_row_nxt = cmd_r.row;
              cur_col_nxt = cmd_r.column;
              rep_we_nxt  = shown;
            end else begin
              status_nxt = 1'b1;
            end
          end
          OP_SET_MODE: begin
            mode_nxt = cmd_r.video_mode;
          end
          OP_CLEAR: begin
            cnt_nxt        = '0;
            clr_report_nxt = 1'b1;
            state_nxt      = S_CLR;
          end
          OP_CLEAR_EOL: begin
            eol_col_nxt = cur_col_r;
            state_nxt   = S_EOL;
          end
          OP_READ_CELL: begin
            if (in_range) begin
              rep_cell_nxt = 1'b1;
            end else begin
              status_nxt = 1'b1;
              zero_nxt   = 1'b1;
            end
          end
          default: begin
          end
        endcase
      end

      // Move each row up one: read one row ahead, write the cell read last cycle
      S_SCR: begin
        if (cnt_r < CNT_W'(CELL_COUNT - SCREEN_COLS)) begin
          mreq.re    = 1'b1;
          mreq.raddr = rd_src[ADDR_W-1:0];
        end
        if (cnt_r != '0) begin
          mreq.we    = 1'b1;
          mreq.waddr = wr_ptr[ADDR_W-1:0];
          mreq.wdata = (wr_ptr < CNT_W'(CELL_COUNT - SCREEN_COLS)) ? rdata : blank_cell;
        end
        if (cnt_r == CNT_W'(CELL_COUNT)) begin
          cnt_nxt   = '0;
          state_nxt = S_REP;
        end else begin
          cnt_nxt = cnt_r + CNT_W'(1);
        end
      end

      // Blank from the cursor to the row end
      S_EOL: begin
        mreq.we    = 1'b1;
        mreq.waddr = cell_addr(cur_row_r, eol_col_r);
        mreq.wdata = blank_cell;
        if (eol_col_r == COL_W'(SCREEN_COLS - 1)) begin
          state_nxt = S_REP;
        end else begin
          eol_col_nxt = eol_col_r + COL_W'(1);
        end
      end

      // Draw or erase the cursor cell and read the reported cell, forward on a hit
      S_REP: begin
        mreq.we      = rep_we_r;
        mreq.waddr   = cur_addr;
        mreq.wdata   = '{ch: CH_BLANK, attr: rep_attr_r};
        mreq.re      = 1'b1;
        mreq.raddr   = rep_addr;
        fwd_hit_nxt  = rep_we_r && (rep_addr == cur_addr);
        fwd_data_nxt = '{ch: CH_BLANK, attr: rep_attr_r};
        state_nxt    = S_DONE;
      end

      // Hold the result until it is taken
      S_DONE: begin
        if (rsp_ready) begin
          if (accept) begin
            cmd_nxt   = in_cmd;
            state_nxt = S_EXEC;
          end else begin
            state_nxt = S_IDLE;
          end
        end
      end

      default: begin
        state_nxt = S_IDLE;
      end
    endcase
  end

  // Checks
  a_cursor_range: assert property (@(posedge clk) disable iff (!rst_n)
    (int'(cur_row_r) < SCREEN_ROWS) && (int'(cur_col_r) < SCREEN_COLS))
    else $error("cursor left the screen");

  a_write_range: assert property (@(posedge clk) disable iff (!rst_n)
    mreq.we |-> (int'(mreq.waddr) < CELL_COUNT))
    else $error("cell write beyond the screen");

  a_accept_exec: assert property (@(posedge clk) disable iff (!rst_n)
    accept |=> (state_r == S_EXEC))
    else $error("accepted command not executed");

  a_busy_no_accept: assert property (@(posedge clk) disable iff (!rst_n)
    ((state_r == S_CLR) || (state_r == S_SCR) || (state_r == S_EOL)) |-> !in_ready)
    else $error("command taken during a cell pass");

  a_rsp_hold: assert property (@(posedge clk) disable iff (!rst_n)
    (rsp_valid && !rsp_ready) |=> (rsp_valid && $stable(rsp)))
    else $error("stalled result changed");

endmodule

`default_nettype wire

// File: design/text_console_renderer.sv
// Channel   Dir  Handshake      Payload
// in_if     in   valid/ready    opcode, char_code, column, row, video_mode
// out_if    out  valid/ready    status, cursor_row, cursor_col, char_out, attr_out
//
// Most commands pass through execute, cursor-cell update plus report read, and result.
// A scroll adds a pass over every cell through the single cell RAM port pair, clear
// screen a blanking pass over every cell, clear to end of line one write per blanked cell.
// After reset a clearing pass blanks every cell of the RAM; no command is taken during it.
// A result waits in the output register while the next command runs; a stalled result
// holds the sequencer only when its next result is ready.
`default_nettype none

module text_console_renderer (
  input wire        clk,
  input wire        rst_n,
  tcr_in_if.sink    in_if,
  tcr_out_if.source out_if
);
  import tcr_pkg::*;

  cmd_t     in_cmd;
  rsp_t     rsp;
  logic     rsp_valid;
  logic     rsp_ready;
  logic     in_ready;
  mem_req_t mreq;
  cell_t    rdata;

  logic out_valid_r, out_valid_nxt;
  rsp_t out_data_r;

  // Pack the command
  assign in_cmd.opcode     = in_if.opcode;
  assign in_cmd.char_code  = in_if.char_code;
  assign in_cmd.column     = in_if.column;
  assign in_cmd.row        = in_if.row;
  assign in_cmd.video_mode = in_if.video_mode;
  assign in_if.ready       = in_ready;

  tcr_ctrl u_ctrl (
    .clk       (clk),
    .rst_n     (rst_n),
    .in_valid  (in_if.valid),
    .in_ready  (in_ready),
    .in_cmd    (in_cmd),
    .rsp_valid (rsp_valid),
    .rsp_ready (rsp_ready),
    .rsp       (rsp),
    .mreq      (mreq),
    .rdata     (rdata)
  );

  tcr_cell_ram u_ram (
    .clk   (clk),
    .mreq  (mreq),
    .rdata (rdata)
  );

  // Output register: load when empty or being drained
  assign rsp_ready = !out_valid_r || out_if.ready;

  always_comb begin
    out_valid_nxt = out_valid_r;
    if (rsp_valid && rsp_ready) begin
      out_valid_nxt = 1'b1;
    end else if (out_if.ready) begin
      out_valid_nxt = 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      out_valid_r <= 1'b0;
    end else begin
      out_valid_r <= out_valid_nxt;
    end
  end

  always_ff @(posedge clk) begin
    if (rsp_valid && rsp_ready) begin
      out_data_r <= rsp;
    end
  end

  assign out_if.valid      = out_valid_r;
  assign out_if.status     = out_data_r.status;
  assign out_if.cursor_row = out_data_r.cursor_row;
  assign out_if.cursor_col = out_data_r.cursor_col;
  assign out_if.char_out   = out_data_r.char_out;
  assign out_if.attr_out   = out_data_r.attr_out;

endmodule

`default_nettype wire
